/* src/rsl_pkg.sv */
// Shared types, codes and frame table for the rpm shift light stager.
package rsl_pkg;

    typedef logic [1:0]  func_t;
    typedef logic [2:0]  kind_t;
    typedef logic [15:0] rpm_t;
    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  cfg_index_t;
    typedef logic [15:0] cfg_data_t;

    // Input operation codes.
    localparam func_t FUNC_RPM    = 2'd0;
    localparam func_t FUNC_SYNC   = 2'd1;
    localparam func_t FUNC_DEACT  = 2'd2;
    localparam func_t FUNC_RESET  = 2'd3;

    // Light pattern kinds.
    localparam kind_t KIND_START   = 3'd0;
    localparam kind_t KIND_MID     = 3'd1;
    localparam kind_t KIND_STARTUP = 3'd2;
    localparam kind_t KIND_FLASH   = 3'd3;
    localparam kind_t KIND_OFF     = 3'd4;

    // Configuration register indexes.
    localparam cfg_index_t REG_DEF_START  = 3'd0;
    localparam cfg_index_t REG_DEF_MID    = 3'd1;
    localparam cfg_index_t REG_DEF_MAX    = 3'd2;
    localparam cfg_index_t REG_STARTUP    = 3'd3;
    localparam cfg_index_t REG_OFF_HOLD   = 3'd4;
    localparam cfg_index_t REG_WARM_SYNC  = 3'd5;

    // Configuration reset values.
    localparam rpm_t  RST_DEF_START = 16'd14000;
    localparam rpm_t  RST_DEF_MID   = 16'd16000;
    localparam rpm_t  RST_DEF_MAX   = 16'd18000;
    localparam rpm_t  RST_STARTUP   = 16'd2000;
    localparam byte_t RST_OFF_HOLD  = 8'd10;
    localparam byte_t RST_WARM_SYNC = 8'h88;

    // Redline code scaling: base = max(code*50 - 300, 0) * 4.
    localparam logic [13:0] SYNC_SCALE  = 14'd50;
    localparam logic [13:0] SYNC_OFFSET = 14'd300;
    localparam rpm_t        MID_SPAN    = 16'd2000;
    localparam rpm_t        MAX_SPAN    = 16'd4000;

    // One queued result beat.
    typedef struct packed {
        kind_t kind;
        logic  last;
    } result_t;

    function automatic byte_t frame_byte0_of(input kind_t kind);
        byte_t b;
        case (kind)
            KIND_START:   b = 8'h86;
            KIND_MID:     b = 8'hF6;
            KIND_STARTUP: b = 8'h56;
            KIND_FLASH:   b = 8'h0A;
            KIND_OFF:     b = 8'h05;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic byte_t frame_byte1_of(input kind_t kind);
        byte_t b;
        case (kind)
            KIND_START: b = 8'h3E;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/rsl_if.sv */
// Handshake channel interfaces of the rpm shift light stager.
interface rsl_in_if;
    logic             valid;
    logic             ready;
    rsl_pkg::func_t   func;
    rsl_pkg::rpm_t    rpm;
    rsl_pkg::byte_t   sync_byte;

    modport source (output valid, output func, output rpm, output sync_byte, input ready);
    modport sink   (input valid, input func, input rpm, input sync_byte, output ready);
endinterface

interface rsl_out_if;
    logic             valid;
    logic             ready;
    rsl_pkg::kind_t   pattern_kind;
    rsl_pkg::byte_t   frame_byte0;
    rsl_pkg::byte_t   frame_byte1;
    logic             last;

    modport source (output valid, output pattern_kind, output frame_byte0,
                    output frame_byte1, output last, input ready);
    modport sink   (input valid, input pattern_kind, input frame_byte0,
                    input frame_byte1, input last, output ready);
endinterface

interface rsl_cfg_if;
    logic                   valid;
    logic                   ready;
    rsl_pkg::cfg_index_t    index;
    rsl_pkg::cfg_data_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/rpm_shift_light_stager.sv */
// Top level of the rpm shift light stager: item register, staging logic and result queue.

// The stager turns engine events into shift light frames. Each input beat is
// latched into an item register, where a short block of logic
// evaluates it against the running state and pushes zero, one or two frame
// beats into a four-entry result queue, with the last flag set on the final
// frame of that input. A new input beat is taken every cycle as long as the
// queue has room, so inputs that cause at most one frame run at one beat per
// clock, and a sample that causes both the startup and a band frame puts two
// beats on the frame channel. Configuration writes are taken at any time
// (ready is always high) and should only be made while the block is idle; the
// default thresholds take effect the next time the defaults are restored.
module rpm_shift_light_stager (
    input  logic    clk,
    input  logic    rst_n,
    rsl_in_if.sink  sample,
    rsl_out_if.source frame,
    rsl_cfg_if.sink cfg
);
    import rsl_pkg::*;

    // Configuration registers.
    rpm_t  def_start_reg;
    rpm_t  def_mid_reg;
    rpm_t  def_max_reg;
    rpm_t  startup_thr_reg;
    byte_t off_hold_reg;
    byte_t warm_sync_reg;

    // Running state.
    logic  lights_active_reg, lights_active_next;
    byte_t off_skip_reg, off_skip_next;
    byte_t last_sync_reg, last_sync_next;
    rpm_t  act_start_reg, act_start_next;
    rpm_t  act_mid_reg, act_mid_next;
    rpm_t  act_max_reg, act_max_next;
    logic  started_reg, started_next;
    logic  warm_reg, warm_next;

    // Item register.
    logic  item_valid_reg;
    func_t item_func_reg;
    rpm_t  item_rpm_reg;
    byte_t item_sync_reg;

    // Result queue.
    result_t     queue_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    // Staging results.
    logic [1:0]  n_results;
    kind_t       kind0;
    kind_t       kind1;
    logic        proc_fire;
    logic        pop;
    logic [2:0]  count_sum;

    // Sync scaling.
    logic [13:0] sync_raw;
    logic [13:0] sync_less;
    rpm_t        sync_base;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_start_reg   <= RST_DEF_START;
            def_mid_reg     <= RST_DEF_MID;
            def_max_reg     <= RST_DEF_MAX;
            startup_thr_reg <= RST_STARTUP;
            off_hold_reg    <= RST_OFF_HOLD;
            warm_sync_reg   <= RST_WARM_SYNC;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEF_START: def_start_reg   <= cfg.data;
                REG_DEF_MID:   def_mid_reg     <= cfg.data;
                REG_DEF_MAX:   def_max_reg     <= cfg.data;
                REG_STARTUP:   startup_thr_reg <= cfg.data;
                REG_OFF_HOLD:  off_hold_reg    <= cfg.data[7:0];
                REG_WARM_SYNC: warm_sync_reg   <= cfg.data[7:0];
                default:       ;
            endcase
        end
    end

    // The item register frees up whenever its item is staged this cycle.
    assign sample.ready = !item_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            item_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            item_func_reg <= sample.func;
            item_rpm_reg  <= sample.rpm;
            item_sync_reg <= sample.sync_byte;
        end
    end

    // A redline code maps to a base threshold, floored at zero for small codes.
    assign sync_raw  = 14'(item_sync_reg) * SYNC_SCALE;
    assign sync_less = sync_raw - SYNC_OFFSET;
    assign sync_base = (sync_raw >= SYNC_OFFSET) ? {sync_less, 2'b00} : '0;

    always_comb
    begin
        logic  startup;
        logic  have_band;
        kind_t band_kind;

        lights_active_next = lights_active_reg;
        off_skip_next      = off_skip_reg;
        last_sync_next     = last_sync_reg;
        act_start_next     = act_start_reg;
        act_mid_next       = act_mid_reg;
        act_max_next       = act_max_reg;
        started_next       = started_reg;
        warm_next          = warm_reg;
        startup            = 1'b0;
        have_band          = 1'b0;
        band_kind          = KIND_OFF;

        case (item_func_reg)
            FUNC_RPM:
            begin
                if (!started_reg && item_rpm_reg > startup_thr_reg)
                begin
                    startup            = 1'b1;
                    started_next       = 1'b1;
                    lights_active_next = 1'b1;
                    off_skip_next      = off_hold_reg;
                end
                // Bands are tested low to high, so a tie lands in the lower band.
                if (item_rpm_reg >= act_start_reg && item_rpm_reg <= act_mid_reg)
                begin
                    have_band          = 1'b1;
                    band_kind          = KIND_START;
                    lights_active_next = 1'b1;
                end
                else if (item_rpm_reg >= act_mid_reg && item_rpm_reg <= act_max_reg)
                begin
                    have_band          = 1'b1;
                    band_kind          = KIND_MID;
                    lights_active_next = 1'b1;
                end
                else if (item_rpm_reg >= act_max_reg)
                begin
                    have_band          = 1'b1;
                    band_kind          = KIND_FLASH;
                    lights_active_next = 1'b1;
                end
                else if (lights_active_next)
                begin
                    if (off_skip_next == '0)
                    begin
                        have_band          = 1'b1;
                        band_kind          = KIND_OFF;
                        lights_active_next = 1'b0;
                    end
                    else
                    begin
                        off_skip_next = off_skip_next - 8'd1;
                    end
                end
            end
            FUNC_SYNC:
            begin
                if (!warm_reg)
                begin
                    if (item_sync_reg != last_sync_reg)
                    begin
                        act_start_next = sync_base;
                        act_mid_next   = sync_base + MID_SPAN;
                        act_max_next   = sync_base + MAX_SPAN;
                        last_sync_next = item_sync_reg;
                        if (item_sync_reg == warm_sync_reg)
                        begin
                            warm_next = 1'b1;
                        end
                    end
                end
                else if (act_start_reg != def_start_reg)
                begin
                    act_start_next = def_start_reg;
                    act_mid_next   = def_mid_reg;
                    act_max_next   = def_max_reg;
                end
            end
            FUNC_DEACT:
            begin
                if (lights_active_reg)
                begin
                    if (off_skip_reg == '0)
                    begin
                        have_band          = 1'b1;
                        band_kind          = KIND_OFF;
                        lights_active_next = 1'b0;
                    end
                    else
                    begin
                        off_skip_next = off_skip_reg - 8'd1;
                    end
                end
            end
            FUNC_RESET:
            begin
                // Engine started is kept across a runtime reset.
                lights_active_next = 1'b0;
                warm_next          = 1'b0;
                off_skip_next      = '0;
                last_sync_next     = '0;
                act_start_next     = def_start_reg;
                act_mid_next       = def_mid_reg;
                act_max_next       = def_max_reg;
            end
            default:
            begin
            end
        endcase

        n_results = {1'b0, startup} + {1'b0, have_band};
        kind0     = startup ? KIND_STARTUP : band_kind;
        kind1     = band_kind;
    end

    // Stage an item only when the queue can hold all of its frames.
    assign count_sum = count_reg + {1'b0, n_results};
    assign proc_fire = item_valid_reg && (count_sum <= 3'd4);
    assign pop       = frame.valid && frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lights_active_reg <= 1'b0;
            off_skip_reg      <= '0;
            last_sync_reg     <= '0;
            act_start_reg     <= RST_DEF_START;
            act_mid_reg       <= RST_DEF_MID;
            act_max_reg       <= RST_DEF_MAX;
            started_reg       <= 1'b0;
            warm_reg          <= 1'b0;
        end
        else if (proc_fire)
        begin
            lights_active_reg <= lights_active_next;
            off_skip_reg      <= off_skip_next;
            last_sync_reg     <= last_sync_next;
            act_start_reg     <= act_start_next;
            act_mid_reg       <= act_mid_next;
            act_max_reg       <= act_max_next;
            started_reg       <= started_next;
            warm_reg          <= warm_next;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (proc_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_results;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= (proc_fire ? count_sum : count_reg) - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && n_results != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= '{kind: kind0, last: (n_results == 2'd1)};
        end
        if (proc_fire && n_results == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= '{kind: kind1, last: 1'b1};
        end
    end

    assign frame.valid        = (count_reg != '0);
    assign frame.pattern_kind = queue_reg[rd_ptr_reg].kind;
    assign frame.frame_byte0  = frame_byte0_of(queue_reg[rd_ptr_reg].kind);
    assign frame.frame_byte1  = frame_byte1_of(queue_reg[rd_ptr_reg].kind);
    assign frame.last         = queue_reg[rd_ptr_reg].last;

endmodule
